FILE: hdl/first_fit_extent_allocator_macros.svh
// Assertion helpers shared by the allocator modules.
`ifndef FIRST_FIT_EXTENT_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_EXTENT_ALLOCATOR_MACROS_SVH

// Checked property that is ignored while reset is held.
`define FFEA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked property that must also hold during reset.
`define FFEA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hdl/ffea_pkg.sv
package ffea_pkg;

  localparam int unsigned TABLE_ENTRIES = 4096;
  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [31:0] PAGE_ADD  = 32'h0000_0fff;
  localparam logic [31:0] PAGE_MASK = 32'hffff_f000;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_LOST  = 2'd2;

  localparam logic KIND_ALLOC = 1'b0;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] length;
  } extent_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_READ,
    OP_NEXT,
    OP_CARVE,
    OP_FAIL,
    OP_RD_UP1,
    OP_WR_DOWN,
    OP_RD_DN1,
    OP_WR_UP,
    OP_MERGE_PREV,
    OP_MERGE_NEXT,
    OP_MARK_INS,
    OP_INSERT,
    OP_LOST
  } dp_op_t;

  typedef struct packed {
    logic is_alloc;
    logic idx_lt_count;
    logic idx_gt_pos;
    logic fits;
    logic start_gt;
    logic prev_adj;
    logic next_adj;
    logic full;
    logic carve_empty;
  } dp_stat_t;

endpackage

FILE: hdl/ffea_datapath.sv
module ffea_datapath
  import ffea_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  dp_op_t           op,
  output dp_stat_t         stat,
  input  logic             cfg_wr,
  input  logic             cfg_page,
  input  logic             in_kind,
  input  logic [31:0]      in_addr,
  input  logic [31:0]      in_size,
  output logic [31:0]      res_addr,
  output logic [1:0]       res_status,
  output logic [CNT_W-1:0] count,
  output logic [CNT_W-1:0] peak,
  output logic [31:0]      free_total,
  output logic [31:0]      lost_count,
  output logic [31:0]      lost_total
);

  `include "first_fit_extent_allocator_macros.svh"

  extent_t          mem [TABLE_ENTRIES];
  extent_t          rdata_r;
  extent_t          prev_r;
  extent_t          wdata;
  logic [IDX_W-1:0] raddr;
  logic [IDX_W-1:0] waddr;
  logic             re;
  logic             we;

  logic             page_r;
  logic             kind_r;
  logic [31:0]      addr_r;
  logic [31:0]      size_r;
  logic [31:0]      res_r;
  logic [1:0]       stat_r;
  logic [CNT_W-1:0] idx_r;
  logic [CNT_W-1:0] pos_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] peak_r;
  logic [31:0]      free_r;
  logic [31:0]      lostc_r;
  logic [31:0]      lostt_r;
  logic             empty_r;

  logic [31:0]      size_in;
  logic [CNT_W-1:0] count_inc;
  logic             prev_adj;
  logic             next_adj;

  assign size_in   = page_r ? ((in_size + PAGE_ADD) & PAGE_MASK) : in_size;
  assign count_inc = count_r + CNT_W'(1);
  assign prev_adj  = (idx_r != '0) && ((prev_r.start + prev_r.length) == addr_r);
  assign next_adj  = (idx_r < count_r) && ((addr_r + size_r) == rdata_r.start);

  assign stat.is_alloc     = (kind_r == KIND_ALLOC);
  assign stat.idx_lt_count = (idx_r < count_r);
  assign stat.idx_gt_pos   = (idx_r > pos_r);
  assign stat.fits         = (rdata_r.length >= size_r);
  assign stat.start_gt     = (rdata_r.start > addr_r);
  assign stat.prev_adj     = prev_adj;
  assign stat.next_adj     = next_adj;
  assign stat.full         = (count_r == CNT_W'(TABLE_ENTRIES));
  assign stat.carve_empty  = empty_r;

  always_comb begin
    re    = 1'b0;
    we    = 1'b0;
    raddr = idx_r[IDX_W-1:0];
    waddr = idx_r[IDX_W-1:0];
    wdata = rdata_r;
    case (op)
      OP_READ: begin
        re = 1'b1;
      end
      OP_RD_UP1: begin
        re    = 1'b1;
        raddr = idx_r[IDX_W-1:0] + IDX_W'(1);
      end
      OP_RD_DN1: begin
        re    = 1'b1;
        raddr = idx_r[IDX_W-1:0] - IDX_W'(1);
      end
      OP_WR_DOWN, OP_WR_UP: begin
        we = 1'b1;
      end
      OP_CARVE: begin
        we    = 1'b1;
        wdata = '{start: rdata_r.start + size_r, length: rdata_r.length - size_r};
      end
      OP_MERGE_PREV: begin
        we    = 1'b1;
        waddr = idx_r[IDX_W-1:0] - IDX_W'(1);
        wdata = '{start: prev_r.start,
                  length: prev_r.length + size_r + (next_adj ? rdata_r.length : 32'd0)};
      end
      OP_MERGE_NEXT: begin
        we    = 1'b1;
        wdata = '{start: addr_r, length: rdata_r.length + size_r};
      end
      OP_INSERT: begin
        we    = 1'b1;
        wdata = '{start: addr_r, length: size_r};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_r  <= 1'b0;
      count_r <= '0;
      peak_r  <= '0;
      free_r  <= '0;
      lostc_r <= '0;
      lostt_r <= '0;
      idx_r   <= '0;
      pos_r   <= '0;
      stat_r  <= ST_OK;
      res_r   <= '0;
      empty_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        page_r <= cfg_page;
      end
      case (op)
        OP_LOAD: begin
          kind_r <= in_kind;
          addr_r <= in_addr;
          size_r <= size_in;
          idx_r  <= '0;
          res_r  <= '0;
          stat_r <= ST_OK;
        end
        OP_NEXT: begin
          prev_r <= rdata_r;
          idx_r  <= idx_r + CNT_W'(1);
        end
        OP_CARVE: begin
          res_r   <= rdata_r.start;
          free_r  <= free_r - size_r;
          empty_r <= (rdata_r.length == size_r);
          if (rdata_r.length == size_r) begin
            count_r <= count_r - CNT_W'(1);
          end
        end
        OP_FAIL: begin
          stat_r <= ST_NOFIT;
        end
        OP_WR_DOWN: begin
          idx_r <= idx_r + CNT_W'(1);
        end
        OP_WR_UP: begin
          idx_r <= idx_r - CNT_W'(1);
        end
        OP_MERGE_PREV: begin
          free_r <= free_r + size_r;
          if (next_adj) begin
            count_r <= count_r - CNT_W'(1);
          end
        end
        OP_MERGE_NEXT: begin
          free_r <= free_r + size_r;
        end
        OP_MARK_INS: begin
          pos_r <= idx_r;
          idx_r <= count_r;
        end
        OP_INSERT: begin
          free_r  <= free_r + size_r;
          count_r <= count_inc;
          if (peak_r < count_inc) begin
            peak_r <= count_inc;
          end
        end
        OP_LOST: begin
          stat_r  <= ST_LOST;
          lostc_r <= lostc_r + 32'd1;
          lostt_r <= lostt_r + size_r;
        end
        default: begin
        end
      endcase
    end
  end

  assign res_addr   = res_r;
  assign res_status = stat_r;
  assign count      = count_r;
  assign peak       = peak_r;
  assign free_total = free_r;
  assign lost_count = lostc_r;
  assign lost_total = lostt_r;

  `FFEA_ASSERT(a_count_bound, count_r <= CNT_W'(TABLE_ENTRIES), "extent count above table size")
  `FFEA_ASSERT(a_peak_cover, peak_r >= count_r, "peak below current count")
  `FFEA_ASSERT(a_no_insert_full, (op == OP_INSERT) |-> (count_r < CNT_W'(TABLE_ENTRIES)),
               "insert into full table")
  `FFEA_ASSERT_ALWAYS(a_single_port_use, !(we && re), "read and write in one cycle")

endmodule

FILE: hdl/ffea_ctrl.sv
module ffea_ctrl
  import ffea_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_op_t   op
);

  `include "first_fit_extent_allocator_macros.svh"

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_CHECK,
    S_POST,
    S_DN_TEST,
    S_DN_WR,
    S_UP_TEST,
    S_UP_WR,
    S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    op        = OP_NOP;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op        = OP_LOAD;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.idx_lt_count) begin
          op        = OP_READ;
          state_nxt = S_CHECK;
        end else if (stat.is_alloc) begin
          op        = OP_FAIL;
          state_nxt = S_DONE;
        end else if (stat.prev_adj) begin
          op        = OP_MERGE_PREV;
          state_nxt = S_DONE;
        end else if (!stat.full) begin
          op        = OP_MARK_INS;
          state_nxt = S_UP_TEST;
        end else begin
          op        = OP_LOST;
          state_nxt = S_DONE;
        end
      end
      S_CHECK: begin
        if (stat.is_alloc) begin
          if (stat.fits) begin
            op        = OP_CARVE;
            state_nxt = S_POST;
          end else begin
            op        = OP_NEXT;
            state_nxt = S_SCAN;
          end
        end else if (!stat.start_gt) begin
          op        = OP_NEXT;
          state_nxt = S_SCAN;
        end else if (stat.prev_adj) begin
          op        = OP_MERGE_PREV;
          state_nxt = stat.next_adj ? S_DN_TEST : S_DONE;
        end else if (stat.next_adj) begin
          op        = OP_MERGE_NEXT;
          state_nxt = S_DONE;
        end else if (!stat.full) begin
          op        = OP_MARK_INS;
          state_nxt = S_UP_TEST;
        end else begin
          op        = OP_LOST;
          state_nxt = S_DONE;
        end
      end
      S_POST: begin
        state_nxt = stat.carve_empty ? S_DN_TEST : S_DONE;
      end
      S_DN_TEST: begin
        if (stat.idx_lt_count) begin
          op        = OP_RD_UP1;
          state_nxt = S_DN_WR;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DN_WR: begin
        op        = OP_WR_DOWN;
        state_nxt = S_DN_TEST;
      end
      S_UP_TEST: begin
        if (stat.idx_gt_pos) begin
          op        = OP_RD_DN1;
          state_nxt = S_UP_WR;
        end else begin
          op        = OP_INSERT;
          state_nxt = S_DONE;
        end
      end
      S_UP_WR: begin
        op        = OP_WR_UP;
        state_nxt = S_UP_TEST;
      end
      S_DONE: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_DONE);

  `FFEA_ASSERT(a_sides_apart, !(in_ready && out_valid), "input and result open together")
  `FFEA_ASSERT(a_beat_starts_scan, (in_valid && in_ready) |=> (state_r == S_SCAN),
               "accepted beat did not start a scan")
  `FFEA_ASSERT(a_result_held, (out_valid && !out_ready) |=> out_valid, "result dropped early")

endmodule

FILE: hdl/first_fit_extent_allocator.sv
// First-fit free-extent allocator. The block keeps up to 4096 free extents sorted by start
// address in a single-port table and handles one beat at a time: the time a beat takes grows
// with the table entries visited by the first-fit or address search and with the entries moved
// when an extent is removed or inserted, as the table port does one read or write per cycle.
// cfg_data[0] enables rounding of sizes up to 4 KiB and may be written only while idle.
module first_fit_extent_allocator
  import ffea_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_kind,
  input  logic [31:0]      in_req_addr,
  input  logic [31:0]      in_req_size,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [31:0]      out_result_addr,
  output logic [1:0]       out_status,
  output logic [CNT_W-1:0] out_entries_in_use,
  output logic [CNT_W-1:0] out_peak_entries,
  output logic [31:0]      out_free_bytes,
  output logic [31:0]      out_lost_releases,
  output logic [31:0]      out_lost_bytes
);

  dp_op_t   op;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  ffea_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .op        (op)
  );

  ffea_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .op         (op),
    .stat       (stat),
    .cfg_wr     (cfg_valid),
    .cfg_page   (cfg_data),
    .in_kind    (in_kind),
    .in_addr    (in_req_addr),
    .in_size    (in_req_size),
    .res_addr   (out_result_addr),
    .res_status (out_status),
    .count      (out_entries_in_use),
    .peak       (out_peak_entries),
    .free_total (out_free_bytes),
    .lost_count (out_lost_releases),
    .lost_total (out_lost_bytes)
  );

endmodule
